// ===== src/wasc_pkg.sv =====
// Package for the windowed ARQ sender core: sizing constants, event and
// result codes, sequencer state type. No dependencies.
package wasc_pkg;

   localparam int WINDOW_SLOTS = 8;      // chunks per window, 1..64
   localparam int CHUNK_BYTES  = 512;    // bytes per chunk, 1..1023 (chunk length is LEN_W bits)

   localparam int SLOT_W  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int REM_W   = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
   localparam int ADDR_W  = 32;          // byte offsets and file size
   localparam int OFF_W   = ADDR_W + 1;  // retransmit offsets may pass 2^32
   localparam int LEN_W   = 10;
   localparam int OP_W    = 2;
   localparam int KIND_W  = 2;

   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(WINDOW_SLOTS - 1);
   localparam logic [OFF_W-1:0]  CHUNK_OFF  = OFF_W'(CHUNK_BYTES);
   localparam logic [REM_W:0]    CHUNK_REM  = (REM_W+1)'(CHUNK_BYTES);

   // request event codes
   localparam logic [OP_W-1:0] OP_START   = 2'd0;
   localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
   localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_FIRST = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RETX  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_BAD   = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_FILL = 4'b0010,
      ST_RETX = 4'b0100,
      ST_ACK  = 4'b1000
   } seq_state_type;

endpackage

// ===== src/windowed_arq_sender_core.sv =====
// Windowed (selective-repeat) ARQ sender core: top level and sequencer.
// Depends on wasc_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid/req_ready  | op, ack_offset
//  rsp     | out       | rsp_valid/rsp_ready  | kind, chunk_offset, chunk_length,
//          |           |                      | is_final_chunk, relay_odd, last_of_run
//  csr     | in        | csr_valid/csr_ready  | file_size (always ready)
//
// Start: the fill emits one result per cycle while the output register is free.
// Timeout: a scan of the slots, one a cycle, unless stalled at a waiting slot.
// Ack: index search by repeated subtract of the chunk size, then a full
// window fill if the window closes. The file-size, ack and search
// subtractions share one 33-bit subtractor in the sequencer.
// Reset: synchronous; the slot state is flops, no clearing pass.
// Stalls: rsp_ready low freezes the fill, and the retransmit scan at a waiting
// slot, once the output register is full.
module windowed_arq_sender_core
   import wasc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_op,
   input  logic [ADDR_W-1:0]   req_ack_offset,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [ADDR_W-1:0]   rsp_chunk_offset,
   output logic [LEN_W-1:0]    rsp_chunk_length,
   output logic                rsp_is_final_chunk,
   output logic                rsp_relay_odd,
   output logic                rsp_last_of_run,
   // config write
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [ADDR_W-1:0]   csr_file_size
);

   // ---------------------------------------------------------------
   // state
   // ---------------------------------------------------------------
   seq_state_type state_ff, state_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;         // scan / search index
   logic [OFF_W-1:0]        cur_off_ff, cur_off_in;   // chunk offset or ack remainder
   logic [ADDR_W-1:0]       next_off_ff, next_off_in;
   logic [ADDR_W-1:0]       win_start_ff, win_start_in;
   logic                    nxt_par_ff, nxt_par_in;   // chunk parity at next_off
   logic [REM_W-1:0]        nxt_rem_ff, nxt_rem_in;   // next_off modulo chunk size
   logic                    ws_par_ff, ws_par_in;     // chunk parity at win_start
   logic [WINDOW_SLOTS-1:0] used_ff, used_in;         // slot sent in this window
   logic [WINDOW_SLOTS-1:0] wait_ff, wait_in;         // sent, not yet acked
   logic                    active_ff, active_in;
   logic [ADDR_W-1:0]       file_size_ff, file_size_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]       rsp_kind_ff, rsp_kind_in;
   logic [ADDR_W-1:0]       rsp_off_ff, rsp_off_in;
   logic [LEN_W-1:0]        rsp_len_ff, rsp_len_in;
   logic                    rsp_final_ff, rsp_final_in;
   logic                    rsp_relay_ff, rsp_relay_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------
   // shared subtractor: file_size - offset, ack - window_start,
   // remainder - chunk size
   // ---------------------------------------------------------------
   logic [OFF_W-1:0] sub_a, sub_b, diff;
   logic [OFF_W:0]   sub_res;
   logic             borrow;

   always_comb begin
      case (state_ff)
         ST_ACK: begin
            sub_a = cur_off_ff;
            sub_b = CHUNK_OFF;
         end
         ST_FILL, ST_RETX: begin
            sub_a = {1'b0, file_size_ff};
            sub_b = cur_off_ff;
         end
         default: begin
            sub_a = {1'b0, req_ack_offset};
            sub_b = {1'b0, win_start_ff};
         end
      endcase
   end

   assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
   assign borrow  = sub_res[OFF_W];
   assign diff    = sub_res[OFF_W-1:0];

   // offset stepper, one chunk per slot
   logic [OFF_W-1:0] step_off;
   assign step_off = cur_off_ff + CHUNK_OFF;

   // chunk fields from file_size - offset
   logic             em_lt, em_fits, em_final;
   logic [OFF_W-1:0] em_len_full;
   assign em_lt       = !borrow && (diff != '0);
   assign em_fits     = (diff <= CHUNK_OFF);
   assign em_len_full = em_lt ? (em_fits ? diff : CHUNK_OFF) : '0;
   assign em_final    = em_lt ? em_fits : (diff == '0);

   // parity at next_off: flips when the chunk length carries the offset
   // across a chunk boundary (a short last chunk may not)
   logic [REM_W:0] rem_sum, rem_left;
   logic           rem_wrap;
   assign rem_sum  = {1'b0, nxt_rem_ff} + em_len_full[REM_W:0];
   assign rem_wrap = (rem_sum >= CHUNK_REM);
   assign rem_left = rem_wrap ? (rem_sum - CHUNK_REM) : rem_sum;

   // slot masks
   logic [WINDOW_SLOTS-1:0] slot_hot, above_mask, wait_mark;
   always_comb begin
      for (int k = 0; k < WINDOW_SLOTS; k++) begin
         slot_hot[k]   = (k == int'(slot_ff));
         above_mask[k] = (k > int'(slot_ff));
      end
   end
   assign wait_mark = wait_ff & ~(slot_hot & used_ff);

   // ---------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------
   logic              fill_go, fill_par;
   logic [ADDR_W-1:0] fill_base;
   logic [WINDOW_SLOTS-1:0] wait_res;

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      cur_off_in   = cur_off_ff;
      next_off_in  = next_off_ff;
      win_start_in = win_start_ff;
      nxt_par_in   = nxt_par_ff;
      nxt_rem_in   = nxt_rem_ff;
      ws_par_in    = ws_par_ff;
      used_in      = used_ff;
      wait_in      = wait_ff;
      active_in    = active_ff;
      file_size_in = (csr_valid) ? csr_file_size : file_size_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_final_in = rsp_final_ff;
      rsp_relay_in = rsp_relay_ff;
      rsp_last_in  = rsp_last_ff;

      fill_go   = 1'b0;
      fill_base = next_off_ff;
      fill_par  = nxt_par_ff;
      wait_res  = wait_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  OP_START: begin
                     next_off_in = '0;
                     nxt_par_in  = 1'b0;
                     nxt_rem_in  = '0;
                     active_in   = 1'b1;
                     fill_go     = 1'b1;
                     fill_base   = '0;
                     fill_par    = 1'b0;
                  end
                  OP_ACK: begin
                     if (active_ff) begin
                        if (!borrow) begin
                           state_in   = ST_ACK;
                           cur_off_in = diff;
                           slot_in    = '0;
                        end else if (wait_ff == '0) begin
                           fill_go = 1'b1;
                        end
                     end
                  end
                  OP_TIMEOUT: begin
                     if (active_ff && (wait_ff != '0)) begin
                        state_in   = ST_RETX;
                        cur_off_in = {1'b0, win_start_ff};
                        slot_in    = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_ACK: begin
            // remainder below one chunk: slot found; past last slot: ignore
            if (borrow || (slot_ff == SLOT_LAST)) begin
               wait_res = borrow ? wait_mark : wait_ff;
               wait_in  = wait_res;
               state_in = ST_IDLE;
               if (wait_res == '0)
                  fill_go = 1'b1;
            end else begin
               cur_off_in = diff;
               slot_in    = slot_ff + SLOT_W'(1);
            end
         end

         ST_FILL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (em_lt) begin
                  rsp_kind_in       = KIND_FIRST;
                  rsp_off_in        = cur_off_ff[ADDR_W-1:0];
                  rsp_len_in        = em_len_full[LEN_W-1:0];
                  rsp_final_in      = em_final;
                  rsp_relay_in      = nxt_par_ff;
                  rsp_last_in       = em_fits || (slot_ff == SLOT_LAST);
                  used_in[slot_ff]  = 1'b1;
                  wait_in[slot_ff]  = 1'b1;
                  nxt_par_in        = nxt_par_ff ^ rem_wrap;
                  nxt_rem_in        = rem_left[REM_W-1:0];
                  next_off_in       = em_fits ? file_size_ff : step_off[ADDR_W-1:0];
                  cur_off_in        = step_off;
                  slot_in           = slot_ff + SLOT_W'(1);
                  if (em_fits || (slot_ff == SLOT_LAST))
                     state_in = ST_IDLE;
               end else begin
                  // nothing left to send: transfer complete
                  rsp_kind_in  = KIND_DONE;
                  rsp_off_in   = '0;
                  rsp_len_in   = '0;
                  rsp_final_in = 1'b0;
                  rsp_relay_in = 1'b0;
                  rsp_last_in  = 1'b1;
                  active_in    = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end

         ST_RETX: begin
            if (wait_ff[slot_ff]) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_RETX;
                  rsp_off_in   = cur_off_ff[ADDR_W-1:0];
                  rsp_len_in   = em_len_full[LEN_W-1:0];
                  rsp_final_in = em_final;
                  rsp_relay_in = ws_par_ff ^ slot_ff[0];
                  rsp_last_in  = ((wait_ff & above_mask) == '0);
                  cur_off_in   = step_off;
                  slot_in      = slot_ff + SLOT_W'(1);
                  if ((wait_ff & above_mask) == '0)
                     state_in = ST_IDLE;
               end
            end else begin
               cur_off_in = step_off;
               slot_in    = slot_ff + SLOT_W'(1);
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // open a new window at fill_base
      if (fill_go) begin
         state_in     = ST_FILL;
         cur_off_in   = {1'b0, fill_base};
         win_start_in = fill_base;
         ws_par_in    = fill_par;
         used_in      = '0;
         wait_in      = '0;
         slot_in      = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_off_ff  <= '0;
         win_start_ff <= '0;
         nxt_par_ff   <= 1'b0;
         nxt_rem_ff   <= '0;
         ws_par_ff    <= 1'b0;
         used_ff      <= '0;
         wait_ff      <= '0;
         active_ff    <= 1'b0;
         file_size_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_off_ff  <= next_off_in;
         win_start_ff <= win_start_in;
         nxt_par_ff   <= nxt_par_in;
         nxt_rem_ff   <= nxt_rem_in;
         ws_par_ff    <= ws_par_in;
         used_ff      <= used_in;
         wait_ff      <= wait_in;
         active_ff    <= active_in;
         file_size_ff <= file_size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      cur_off_ff   <= cur_off_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_final_ff <= rsp_final_in;
      rsp_relay_ff <= rsp_relay_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_chunk_offset   = rsp_off_ff;
   assign rsp_chunk_length   = rsp_len_ff;
   assign rsp_is_final_chunk = rsp_final_ff;
   assign rsp_relay_odd      = rsp_relay_ff;
   assign rsp_last_of_run    = rsp_last_ff;

endmodule

// ===== src/wasc_checker.sv =====
// Port-level checks for windowed_arq_sender_core, bound to the top level.
// Depends on wasc_pkg.
module wasc_checker
   import wasc_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [KIND_W-1:0]   rsp_kind,
   input logic [ADDR_W-1:0]   rsp_chunk_offset,
   input logic [LEN_W-1:0]    rsp_chunk_length,
   input logic                rsp_is_final_chunk,
   input logic                rsp_relay_odd,
   input logic                rsp_last_of_run
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_chunk_offset)
         && $stable(rsp_kind) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // complete result is bare and ends its run
   a_done_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DONE |-> rsp_last_of_run
         && rsp_chunk_offset == '0 && rsp_chunk_length == '0
         && !rsp_is_final_chunk && !rsp_relay_odd)
      else $error("malformed complete result");

   // a first send of the final chunk ends its run
   a_final_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FIRST && rsp_is_final_chunk |-> rsp_last_of_run)
      else $error("final chunk not last of run");

   // more results pending: no new request taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> !req_ready)
      else $error("request accepted mid-run");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind != KIND_BAD)
      else $error("bad result kind");

endmodule

bind windowed_arq_sender_core wasc_checker u_wasc_checker (.*);
